>>> rtl/core/rc4d_pkg.sv
// Shared constants for the RC4-drop key data decryptor.
package rc4d_pkg;

  // Byte and table geometry
  localparam int unsigned DataW       = 8;
  localparam int unsigned TableDepth  = 256;
  localparam int unsigned KeySrcBytes = 32;
  localparam int unsigned KeySrcW     = KeySrcBytes * DataW;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIvHigh  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIvLow   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgKekHigh = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgKekLow  = CfgIdxW'(3);

  // Default parameter values
  localparam int unsigned KeyBytesDef  = 32;
  localparam int unsigned DropBytesDef = 256;

endpackage

>>> rtl/core/rc4_drop256_key_data_decrypt_top.sv
// RC4-drop key data decryptor: key schedule, drop and keystream XOR on one table RAM.
// Plain byte: GenRdI, GenRdJ, GenWrI, GenWrJ, result registered; bytes are taken only in idle.
// Rekey byte (first byte of a message, or any byte before the first keying): 256-entry fill
//   + key schedule over all 256 entries + DropBytes discarded bytes, then the plain-byte steps.
// The table RAM has one write and one registered read port; a full result stalls GenWrJ.
// Reset (rst_ni low, asynchronous) clears indices, keyed flag, key registers and result valid.
module rc4_drop256_key_data_decrypt_top #(
  parameter int unsigned KeyBytes  = rc4d_pkg::KeyBytesDef,
  parameter int unsigned DropBytes = rc4d_pkg::DropBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input bytes
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [rc4d_pkg::DataW-1:0]    s_axis_tdata_i,  // [7:0] data_byte
  input  logic                          s_axis_tuser_i,  // [0] first_byte
  input  logic                          s_axis_tlast_i,  // last_byte
  // Result bytes
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [rc4d_pkg::DataW-1:0]    m_axis_tdata_o,  // [7:0] out_byte
  output logic                          m_axis_tlast_o,  // out_last
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rc4d_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rc4d_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned KeyW   = (KeyBytes > 1) ? $clog2(KeyBytes) : 1;
  localparam int unsigned DropW  = (DropBytes > 0) ? $clog2(DropBytes + 1) : 1;
  localparam int unsigned AddrW  = $clog2(rc4d_pkg::TableDepth);
  localparam logic [KeyW-1:0]  KeyLast  = KeyW'(KeyBytes - 1);
  localparam logic [DropW-1:0] DropLoad = DropW'(DropBytes);
  localparam logic [AddrW-1:0] AddrLast = {AddrW{1'b1}};

  typedef enum logic [9:0] {
    StIdle    = 10'b0000000001,
    StFill    = 10'b0000000010,
    StKsRdI   = 10'b0000000100,
    StKsRdJ   = 10'b0000001000,
    StKsWrI   = 10'b0000010000,
    StKsWrJ   = 10'b0000100000,
    StGenRdI  = 10'b0001000000,
    StGenRdJ  = 10'b0010000000,
    StGenWrI  = 10'b0100000000,
    StGenWrJ  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [rc4d_pkg::CfgDataW-1:0] iv_high_q, iv_low_q, kek_high_q, kek_low_q;
  logic [AddrW-1:0] n_q, n_d;
  logic [AddrW-1:0] i_q, i_d;
  logic [AddrW-1:0] j_q, j_d;
  logic [KeyW-1:0]  k_q, k_d;
  logic [DropW-1:0] drop_q, drop_d;
  logic             keyed_q, keyed_d;
  logic [rc4d_pkg::DataW-1:0] a_q, a_d, b_q, b_d;
  logic [rc4d_pkg::DataW-1:0] data_q, data_d;
  logic             last_q, last_d;
  logic             m_valid_q, m_valid_d;
  logic [rc4d_pkg::DataW-1:0] m_data_q, m_data_d;
  logic             m_last_q, m_last_d;

  logic                       ram_we, ram_re;
  logic [AddrW-1:0]           ram_waddr, ram_raddr;
  logic [rc4d_pkg::DataW-1:0] ram_wdata, ram_rdata;

  logic [rc4d_pkg::KeySrcW-1:0] key_src;
  logic [8:0]                   k_ext;
  logic [rc4d_pkg::DataW-1:0]   key_b;
  logic [AddrW-1:0]             ab_sum;
  logic [rc4d_pkg::DataW-1:0]   ks_byte;
  logic                         in_fire, out_free;

  assign cfg_ready_o = 1'b1;

  // Latch configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_high_q  <= '0;
      iv_low_q   <= '0;
      kek_high_q <= '0;
      kek_low_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rc4d_pkg::CfgIvHigh:  iv_high_q  <= cfg_data_i;
        rc4d_pkg::CfgIvLow:   iv_low_q   <= cfg_data_i;
        rc4d_pkg::CfgKekHigh: kek_high_q <= cfg_data_i;
        rc4d_pkg::CfgKekLow:  kek_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Select key byte k; positions past the key source read as zero
  assign key_src = {iv_high_q, iv_low_q, kek_high_q, kek_low_q};
  assign k_ext   = 9'(k_q);
  always_comb begin
    key_b = '0;
    if (k_ext < 9'(rc4d_pkg::KeySrcBytes)) begin
      key_b = key_src[rc4d_pkg::KeySrcW - 1 - 8 * int'(k_ext[4:0]) -: 8];
    end
  end

  // Keystream byte after the swap: forward the swapped entries
  assign ab_sum = a_q + b_q;
  always_comb begin
    if (ab_sum == j_q) begin
      ks_byte = a_q;
    end else if (ab_sum == i_q) begin
      ks_byte = b_q;
    end else begin
      ks_byte = ram_rdata;
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // Sequencer over the shared table RAM
  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    drop_d    = drop_q;
    keyed_d   = keyed_q;
    a_d       = a_q;
    b_d       = b_q;
    data_d    = data_q;
    last_d    = last_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    ram_we    = 1'b0;
    ram_waddr = n_q;
    ram_wdata = n_q;
    ram_re    = 1'b0;
    ram_raddr = n_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          data_d = s_axis_tdata_i;
          last_d = s_axis_tlast_i;
          if (s_axis_tuser_i || !keyed_q) begin
            n_d     = '0;
            state_d = StFill;
          end else begin
            state_d = StGenRdI;
          end
        end
      end
      StFill: begin
        // Write identity permutation
        ram_we = 1'b1;
        n_d    = n_q + 1'b1;
        if (n_q == AddrLast) begin
          j_d     = '0;
          k_d     = '0;
          state_d = StKsRdI;
        end
      end
      StKsRdI: begin
        ram_re  = 1'b1;
        state_d = StKsRdJ;
      end
      StKsRdJ: begin
        a_d       = ram_rdata;
        j_d       = j_q + ram_rdata + key_b;
        ram_re    = 1'b1;
        ram_raddr = j_d;
        state_d   = StKsWrI;
      end
      StKsWrI: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        state_d   = StKsWrJ;
      end
      StKsWrJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = a_q;
        n_d       = n_q + 1'b1;
        k_d       = (k_q == KeyLast) ? '0 : k_q + 1'b1;
        if (n_q == AddrLast) begin
          i_d     = '0;
          j_d     = '0;
          drop_d  = DropLoad;
          keyed_d = 1'b1;
          state_d = StGenRdI;
        end else begin
          state_d = StKsRdI;
        end
      end
      StGenRdI: begin
        i_d       = i_q + 1'b1;
        ram_re    = 1'b1;
        ram_raddr = i_d;
        state_d   = StGenRdJ;
      end
      StGenRdJ: begin
        a_d       = ram_rdata;
        j_d       = j_q + ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = j_d;
        state_d   = StGenWrI;
      end
      StGenWrI: begin
        b_d       = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = a_q + ram_rdata;
        state_d   = StGenWrJ;
      end
      StGenWrJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = a_q;
        if (drop_q != '0) begin
          // Discard this keystream byte
          drop_d  = drop_q - 1'b1;
          state_d = StGenRdI;
        end else if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = data_q ^ ks_byte;
          m_last_d  = last_q;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      n_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      drop_q    <= '0;
      keyed_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      drop_q    <= drop_d;
      keyed_q   <= keyed_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    data_q   <= data_d;
    last_q   <= last_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
  end

  rc4d_ram #(
    .Width (rc4d_pkg::DataW),
    .Depth (rc4d_pkg::TableDepth)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // Once keyed, the block stays keyed
  a_keyed_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    keyed_q |=> keyed_q)
    else $error("keyed flag dropped");

  // An accepted byte always starts the sequencer
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StFill || state_q == StGenRdI))
    else $error("accepted byte did not start work");

  // Keystream generation only runs on a keyed table
  a_gen_keyed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StGenRdI || state_q == StGenRdJ || state_q == StGenWrI ||
     state_q == StGenWrJ) |-> keyed_q)
    else $error("keystream generation on unkeyed table");

  // Drop count is drained before the block goes idle
  a_drop_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drop_q != '0) |-> (state_q != StIdle))
    else $error("idle with discard pending");

  // A new result comes only out of the final keystream step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == StGenWrJ))
    else $error("result loaded outside keystream step");

endmodule

>>> rtl/core/rc4d_ram.sv
// Generic simple dual-port RAM with registered read data.
module rc4d_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
